### rtl/tdls_pkg.sv
// ----------------------------------------------------------------------------
// tdls_pkg
// Shared types, constants and helper functions for the timestamp slug block.
// ----------------------------------------------------------------------------
package tdls_pkg;

  localparam int MaxDigits  = 19;
  localparam int BcdDigits  = 20;
  localparam int TsWidth    = 64;
  localparam int RndBytes   = 19;
  localparam int LenWidth   = 5;
  localparam int CharWidth  = 7;
  localparam int BitsPerCyc = 4;
  localparam int ConvCycles = TsWidth / BitsPerCyc;
  localparam int CntWidth   = $clog2(ConvCycles);

  localparam logic [LenWidth-1:0] LenReset = 5'd16;
  localparam logic [LenWidth-1:0] Len10    = 5'd10;
  localparam logic [LenWidth-1:0] Len13    = 5'd13;
  localparam logic [LenWidth-1:0] Len16    = 5'd16;
  localparam logic [LenWidth-1:0] Len19    = 5'd19;

  localparam logic [CharWidth-1:0] HyphenChar = 7'h2d;
  localparam logic [CharWidth-1:0] NullChar   = 7'h00;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrLength  = 2'd1,
    ErrTooLong = 2'd2
  } err_t;

  typedef struct packed {
    logic [MaxDigits-1:0][3:0] digits;
    logic [RndBytes-1:0][7:0]  rnd;
    logic [LenWidth-1:0]       len;
    err_t                      err;
  } entry_t;

  localparam logic [7:0] LetterTab [10][6] = '{
    '{"q", "W", "e", "R", "t", "Y"},
    '{"Q", "w", "E", "r", "T", "y"},
    '{"u", "I", "o", "P", "a", 8'h00},
    '{"U", "i", "O", "p", "A", 8'h00},
    '{"s", "D", "f", "G", "h", 8'h00},
    '{"S", "d", "F", "g", "H", 8'h00},
    '{"j", "K", "l", "Z", "x", 8'h00},
    '{"J", "k", "L", "z", "X", 8'h00},
    '{"c", "V", "b", "N", "m", 8'h00},
    '{"C", "v", "B", "n", "M", 8'h00}
  };

  // r mod 5 via reciprocal multiply (exact for 8-bit r)
  function automatic logic [2:0] mod5(input logic [7:0] r);
    logic [17:0] p;
    logic [7:0]  q;
    logic [7:0]  m;
    p = {10'd0, r} * 18'd205;
    q = p[17:10];
    m = r - 8'(q * 8'd5);
    return m[2:0];
  endfunction

  // r mod 6 via reciprocal multiply (exact for 8-bit r)
  function automatic logic [2:0] mod6(input logic [7:0] r);
    logic [17:0] p;
    logic [7:0]  q;
    logic [7:0]  m;
    p = {10'd0, r} * 18'd171;
    q = p[17:10];
    m = r - 8'(q * 8'd6);
    return m[2:0];
  endfunction

  function automatic logic [CharWidth-1:0] slug_letter(input logic [3:0] d,
                                                       input logic [7:0] r);
    logic [2:0] pick;
    logic [7:0] ch;
    if (d < 4'd2) begin
      pick = mod6(r);
    end else begin
      pick = mod5(r);
    end
    ch = LetterTab[d][pick];
    return ch[CharWidth-1:0];
  endfunction

endpackage

### rtl/timestamp_digit_letter_slug.sv
// Flow: the BCD front takes a new item only once its conversion is done; the
//   one-character result channel gives len+1 characters per item (11 to 20).
// Error items give one result and run at the front's pace.
// Reset: synchronous active-low; length register resets to 16, queue empties.
// ----------------------------------------------------------------------------
// timestamp_digit_letter_slug
// Top level: config register, conversion front, two-entry queue, back end.
// ----------------------------------------------------------------------------
module timestamp_digit_letter_slug (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tdls_pkg::LenWidth-1:0]  cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [63:0]                    in_timestamp,
  input  logic [63:0]                    in_random_low,
  input  logic [63:0]                    in_random_mid,
  input  logic [23:0]                    in_random_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tdls_pkg::CharWidth-1:0] out_character,
  output logic                           out_last_char,
  output logic [1:0]                     out_error_code
);
  import tdls_pkg::*;

  logic [LenWidth-1:0] len_cfg_r;
  logic                push;
  logic                push_ready;
  entry_t              push_data;
  logic                q_valid;
  logic                q_pop;
  entry_t              q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LenReset;
    end else if (cfg_wr_en) begin
      len_cfg_r <= cfg_wr_data;
    end
  end

  tdls_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .len_cfg        (len_cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_timestamp   (in_timestamp),
    .in_random_low  (in_random_low),
    .in_random_mid  (in_random_mid),
    .in_random_high (in_random_high),
    .push           (push),
    .push_data      (push_data),
    .push_ready     (push_ready)
  );

  tdls_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_data),
    .wr_ready (push_ready),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_data)
  );

  tdls_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_data         (q_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last_char  (out_last_char),
    .out_error_code (out_error_code)
  );

endmodule

### rtl/tdls_front.sv
// ----------------------------------------------------------------------------
// tdls_front
// Accepts items, converts the timestamp to BCD four bits per cycle and
// classifies length and overflow errors before handing off to the queue.
// ----------------------------------------------------------------------------
module tdls_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tdls_pkg::LenWidth-1:0] len_cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   in_timestamp,
  input  logic [63:0]                   in_random_low,
  input  logic [63:0]                   in_random_mid,
  input  logic [23:0]                   in_random_high,
  output logic                          push,
  output tdls_pkg::entry_t              push_data,
  input  logic                          push_ready
);
  import tdls_pkg::*;

  logic                          busy_r, busy_nxt;
  logic                          conv_done_r, conv_done_nxt;
  logic [CntWidth-1:0]           cnt_r, cnt_nxt;
  logic [TsWidth-1:0]            bin_r, bin_nxt;
  logic [BcdDigits-1:0][3:0]     bcd_r, bcd_nxt;
  logic [RndBytes-1:0][7:0]      rnd_r;
  logic [LenWidth-1:0]           len_r;
  logic                          accept;
  logic                          len_ok;
  logic                          too_long;

  assign in_ready = !busy_r || (conv_done_r && push_ready);
  assign accept   = in_valid && in_ready;
  assign push     = busy_r && conv_done_r && push_ready;

  always_comb begin
    logic [BcdDigits-1:0][3:0] b;
    logic [TsWidth-1:0]        v;
    b = bcd_r;
    v = bin_r;
    for (int s = 0; s < BitsPerCyc; s++) begin
      for (int k = 0; k < BcdDigits; k++) begin
        if (b[k] >= 4'd5) begin
          b[k] = b[k] + 4'd3;
        end
      end
      {b, v} = {b, v} << 1;
    end
    bcd_nxt = b;
    bin_nxt = v;
  end

  always_comb begin
    len_ok = (len_r == Len10) || (len_r == Len13) || (len_r == Len16) ||
             (len_r == Len19);
    too_long = 1'b0;
    for (int j = 0; j < BcdDigits; j++) begin
      if ((5'(j) >= len_r) && (bcd_r[j] != 4'd0)) begin
        too_long = 1'b1;
      end
    end
  end

  always_comb begin
    push_data.digits = bcd_r[MaxDigits-1:0];
    push_data.rnd    = rnd_r;
    push_data.len    = len_r;
    if (!len_ok) begin
      push_data.err = ErrLength;
    end else if (too_long) begin
      push_data.err = ErrTooLong;
    end else begin
      push_data.err = ErrNone;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    conv_done_nxt = conv_done_r;
    cnt_nxt       = cnt_r;
    if (push) begin
      busy_nxt = 1'b0;
    end
    if (busy_r && !conv_done_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntWidth'(ConvCycles - 1)) begin
        conv_done_nxt = 1'b1;
      end
    end
    if (accept) begin
      busy_nxt      = 1'b1;
      conv_done_nxt = 1'b0;
      cnt_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      conv_done_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      conv_done_r <= conv_done_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r <= in_timestamp;
      bcd_r <= '0;
      rnd_r <= {in_random_high, in_random_mid, in_random_low};
      len_r <= len_cfg;
    end else if (busy_r && !conv_done_r) begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
    end
  end

endmodule

### rtl/tdls_fifo.sv
// ----------------------------------------------------------------------------
// tdls_fifo
// Two-entry queue between the conversion front and the character back end.
// ----------------------------------------------------------------------------
module tdls_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  tdls_pkg::entry_t wr_data,
  output logic             wr_ready,
  output logic             rd_valid,
  input  logic             rd_en,
  output tdls_pkg::entry_t rd_data
);
  import tdls_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/tdls_back.sv
// ----------------------------------------------------------------------------
// tdls_back
// Walks one queued entry digit by digit, inserts the hyphen and drives the
// registered result channel; an error entry gives a single null character.
// ----------------------------------------------------------------------------
module tdls_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  tdls_pkg::entry_t               q_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tdls_pkg::CharWidth-1:0] out_character,
  output logic                           out_last_char,
  output logic [1:0]                     out_error_code
);
  import tdls_pkg::*;

  entry_t                ent_r;
  logic                  active_r;
  logic [LenWidth-1:0]   idx_r;
  logic                  hy_done_r;
  logic                  out_valid_r;
  logic [CharWidth-1:0]  out_char_r;
  logic                  out_last_r;
  logic [1:0]            out_err_r;

  logic                  step;
  logic                  is_hy;
  logic                  is_last;
  logic                  finish;
  logic [LenWidth-1:0]   half;
  logic [LenWidth-1:0]   dpos;
  logic [CharWidth-1:0]  letter;

  assign half    = ent_r.len >> 1;
  assign dpos    = ent_r.len - 5'd1 - idx_r;
  assign letter  = slug_letter(ent_r.digits[dpos], ent_r.rnd[idx_r]);
  assign step    = active_r && (!out_valid_r || out_ready);
  assign is_hy   = (idx_r == half) && !hy_done_r;
  assign is_last = (idx_r == ent_r.len - 5'd1);
  assign finish  = step && ((ent_r.err != ErrNone) || (!is_hy && is_last));
  assign q_pop   = q_valid && (!active_r || finish);

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last_char  = out_last_r;
  assign out_error_code = out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hy_done_r   <= 1'b0;
    end else begin
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (step && ent_r.err == ErrNone) begin
        if (is_hy) begin
          hy_done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 5'd1;
        end
      end
      if (finish) begin
        active_r <= 1'b0;
      end
      if (q_pop) begin
        active_r  <= 1'b1;
        idx_r     <= '0;
        hy_done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_data;
    end
    if (step) begin
      if (ent_r.err != ErrNone) begin
        out_char_r <= NullChar;
        out_last_r <= 1'b1;
        out_err_r  <= ent_r.err;
      end else if (is_hy) begin
        out_char_r <= HyphenChar;
        out_last_r <= 1'b0;
        out_err_r  <= ErrNone;
      end else begin
        out_char_r <= letter;
        out_last_r <= is_last;
        out_err_r  <= ErrNone;
      end
    end
  end

endmodule
